// ===== design/bari_pkg.sv =====
// ----------------------------------------------------------------------------
// bari_pkg
// Shared widths, constants and types of the binarizer with isolated pixel
// removal.
// ----------------------------------------------------------------------------
package bari_pkg;

    // Pixel channels and result pixel
    localparam int PIX_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int THR_W      = 8;
    localparam int FW_W       = 11;
    localparam int CFG_DATA_W = FW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd1;

    localparam logic [THR_W-1:0] THR_RESET = 8'd150;
    localparam logic [FW_W-1:0]  FW_RESET  = 11'd720;
    localparam int               MIN_WIDTH = 3;

    // Row counter saturates at its all-ones value
    localparam int ROW_W = 11;

    // Gray conversion: (1868*B + 9617*G + 4899*R + 8192) >> 14
    localparam int GRAY_SHIFT = 14;
    localparam int GRAY_SUM_W = GRAY_SHIFT + PIX_W;
    localparam logic [GRAY_SUM_W-1:0] GRAY_B_COEF = 22'd1868;
    localparam logic [GRAY_SUM_W-1:0] GRAY_G_COEF = 22'd9617;
    localparam logic [GRAY_SUM_W-1:0] GRAY_R_COEF = 22'd4899;
    localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND  = 22'd8192;

    // One entry of the line store: lit bits of the two rows above
    typedef struct packed {
        logic upper;
        logic middle;
    } t_line_pair;

endpackage

// ===== design/bari_line_store.sv =====
// ----------------------------------------------------------------------------
// bari_line_store
// Two-row line buffer, one bit per row and column, with one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module bari_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output bari_pkg::t_line_pair  o_rd_data,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  bari_pkg::t_line_pair  i_wr_data
);
    import bari_pkg::*;

    t_line_pair r_mem [DEPTH];
    t_line_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold the last read while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/binarize_and_remove_isolated_pixels.sv =====
// ----------------------------------------------------------------------------
// binarize_and_remove_isolated_pixels
// Gray threshold binarizer with 3x3 isolated lit pixel removal.
// ----------------------------------------------------------------------------
// Takes one BGR pixel per clock in raster order and returns one 0/255 pixel
// per clock: an input beat is accepted every cycle unless the result side
// stalls. Each beat passes two register stages (line-store read, then the
// result register), and the line store is read and written once per cycle.
// A result belongs to the pixel one row plus one pixel before the beat that
// produces it, so the first row and the first beat of every row give no
// result except the wrap result for the end of the row two above. End each
// frame with frame_width+1 pad beats to flush its last row; last_of_frame
// flags the final pixel of that row. Rows above the first of a frame read as
// dark, so the line store needs no clearing after reset. Configuration
// writes are taken in any cycle and must happen while the stream is idle.
// ----------------------------------------------------------------------------
module binarize_and_remove_isolated_pixels #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [bari_pkg::PIX_W-1:0]       i_blue,
    input  logic [bari_pkg::PIX_W-1:0]       i_green,
    input  logic [bari_pkg::PIX_W-1:0]       i_red,
    input  logic                             i_start_frame,
    input  logic                             i_pad,

    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [bari_pkg::PIX_W-1:0]       o_clean_pixel,
    output logic                             o_last_of_frame,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bari_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bari_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bari_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW    = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int WIN_W = 9;

    localparam logic [XW-1:0]    MAX_W        = XW'(MAX_WIDTH);
    localparam logic [XW-1:0]    MIN_W        = XW'(MIN_WIDTH);
    localparam logic [WIN_W-1:0] WIN_NBR_MASK = 9'h1EF;
    localparam logic [WIN_W-1:0] WIN_NO_LEFT  = 9'h1F8;

    // centre is bit 4; it stays lit only with a lit neighbour
    function automatic logic keep_lit(input logic [WIN_W-1:0] win);
        return win[4] && ((win & WIN_NBR_MASK) != '0);
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [THR_W-1:0] r_gray_threshold;
    logic [FW_W-1:0]  r_frame_width;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_threshold <= THR_RESET;
            r_frame_width    <= FW_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRAY_THRESHOLD: r_gray_threshold <= i_cfg_data[THR_W-1:0];
                CFG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [XW-1:0] fw_ext;
    logic [XW-1:0] w_eff;

    assign fw_ext = XW'(r_frame_width);
    assign w_eff  = (fw_ext < MIN_W) ? MIN_W : ((fw_ext > MAX_W) ? MAX_W : fw_ext);

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic r_a_valid;
    logic r_o_valid;
    logic o_free;
    logic a_adv;
    logic accept;

    assign o_free  = !r_o_valid || !i_stall;
    assign a_adv   = r_a_valid && o_free;
    assign o_stall = r_a_valid && !o_free;
    assign accept  = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Accept: gray, threshold, position counters
    // ------------------------------------------------------------------
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [PIX_W-1:0]      gray;
    logic                  lit_in;

    assign gray_sum = GRAY_SUM_W'(i_blue)  * GRAY_B_COEF
                    + GRAY_SUM_W'(i_green) * GRAY_G_COEF
                    + GRAY_SUM_W'(i_red)   * GRAY_R_COEF
                    + GRAY_ROUND;
    assign gray     = gray_sum[GRAY_SUM_W-1 -: PIX_W];
    assign lit_in   = !i_pad && (gray > r_gray_threshold);

    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_cur_pad;
    logic             r_prev_pad;
    logic             r_prev2_pad;

    logic [CW-1:0]    col_in;
    logic [ROW_W-1:0] row_in;
    logic [XW-1:0]    col_plus;
    logic             row_end;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic             n_cur_pad;

    assign col_in    = i_start_frame ? '0 : r_col;
    assign row_in    = i_start_frame ? '0 : r_row;
    assign col_plus  = XW'(col_in) + XW'(1);
    assign row_end   = (col_plus >= w_eff);
    assign n_col     = row_end ? '0 : col_plus[CW-1:0];
    assign n_row     = (row_end && (row_in != '1)) ? row_in + ROW_W'(1) : row_in;
    assign n_cur_pad = (col_in == '0) ? i_pad : (r_cur_pad && i_pad);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_cur_pad   <= 1'b0;
            r_prev_pad  <= 1'b0;
            r_prev2_pad <= 1'b0;
        end else if (accept) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_cur_pad <= n_cur_pad;
            if (row_end) begin
                r_prev2_pad <= r_prev_pad;
                r_prev_pad  <= n_cur_pad;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: line-store data arrives, window and decision
    // ------------------------------------------------------------------
    logic             r_a_lit;
    logic [CW-1:0]    r_a_col;
    logic [ROW_W-1:0] r_a_row;
    logic             r_a_start;
    logic             r_a_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_stall) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_lit   <= lit_in;
            r_a_col   <= col_in;
            r_a_row   <= row_in;
            r_a_start <= i_start_frame;
            r_a_last  <= r_prev_pad && !r_prev2_pad;
        end
    end

    t_line_pair ls_rd;
    t_line_pair ls_wr;

    bari_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col_in),
        .o_rd_data (ls_rd),
        .i_wr_en   (a_adv),
        .i_wr_addr (r_a_col),
        .i_wr_data (ls_wr)
    );

    logic [WIN_W-1:0] r_win;
    logic [WIN_W-1:0] win_old;
    logic [WIN_W-1:0] n_win;
    logic [WIN_W-1:0] win_cur;
    logic             row_ge1;
    logic             row_ge2;
    logic             up_bit;
    logic             mid_bit;
    logic             res_wrap;
    logic             res_main;
    logic             res_valid;
    logic             res_lit;
    logic             res_last;

    assign row_ge1 = (r_a_row != '0);
    assign row_ge2 = (r_a_row[ROW_W-1:1] != '0);
    assign up_bit  = row_ge2 && ls_rd.upper;
    assign mid_bit = row_ge1 && ls_rd.middle;

    assign ls_wr.upper  = mid_bit;
    assign ls_wr.middle = r_a_lit;

    assign win_old = r_a_start ? '0 : r_win;
    assign n_win   = {r_a_lit, mid_bit, up_bit, win_old[WIN_W-1:3]};
    // drop the left column at the start of a row
    assign win_cur = (r_a_col == CW'(1)) ? (n_win & WIN_NO_LEFT) : n_win;

    assign res_wrap  = (r_a_col == '0) && row_ge2;
    assign res_main  = (r_a_col != '0) && row_ge1;
    assign res_valid = res_wrap || res_main;
    assign res_lit   = res_wrap ? keep_lit({3'b000, win_old[WIN_W-1:3]}) : keep_lit(win_cur);
    assign res_last  = res_wrap && r_a_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (a_adv) begin
            r_win <= n_win;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic r_o_lit;
    logic r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= a_adv && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && res_valid) begin
            r_o_lit  <= res_lit;
            r_o_last <= res_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_clean_pixel   = {PIX_W{r_o_lit}};
    assign o_last_of_frame = r_o_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_start_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_start_frame |=> (r_a_col == '0) && (r_a_row == '0))
        else $error("start beat did not enter at column zero of row zero");

    a_first_row_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_adv && (r_a_row == '0) |=> !r_o_valid)
        else $error("beat of the first row produced a result");

    a_pixel_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_clean_pixel == '0) || (o_clean_pixel == '1))
        else $error("result pixel is neither dark nor lit");

endmodule
